/* src/bgb_pkg.sv */
// Shared types, constants and weight function for the binomial blur block.
package bgb_pkg;

  // Fixed field and register widths.
  localparam int PIXEL_W      = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  // Register values after reset.
  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 16'd480;

  // Command code of an input item that stands for a zero pixel past the frame.
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  // Flags that travel with an item down the pipeline.
  typedef struct packed {
    logic result;
    logic row_end;
    logic frame_end;
  } res_flags_t;

  // One finished result as held in the output queue.
  typedef struct packed {
    pixel_t blurred;
    logic   row_end;
    logic   frame_end;
  } result_t;

  // Control of one line store row.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic bypass;
  } line_ctl_t;

  // Control of one window column.
  typedef struct packed {
    logic clear;
    logic shift;
    logic flush;
  } win_ctl_t;

  // Binomial coefficient n over k, built row by row of Pascal's triangle.
  function automatic int binomial(input int n, input int k);
    int row [16];
    for (int i = 0; i < 16; i++) begin
      row[i] = 0;
    end
    row[0] = 1;
    for (int m = 1; m <= n; m++) begin
      for (int j = m; j > 0; j--) begin
        row[j] = row[j] + row[j-1];
      end
    end
    return row[k];
  endfunction

endpackage

/* src/bgb_if.sv */
// Valid/ready channel interfaces for pixel items and blurred result items.
interface bgb_pixel_if import bgb_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  pixel_t pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface bgb_result_if import bgb_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t blurred;
  logic   row_end;
  logic   frame_end;

  modport source (output valid, output blurred, output row_end, output frame_end, input ready);
  modport sink (input valid, input blurred, input row_end, input frame_end, output ready);
endinterface

/* src/binomial_gaussian_blur_core.sv */
// Top level of the streaming binomial blur: counters, line store, window chain, adder stages.
//
//   channel   | kind          | payload
//   ----------+---------------+-------------------------------------------
//   pixels    | valid / ready | cmd, pixel (8 bits)
//   results   | valid / ready | blurred (8 bits), row_end, frame_end
//   apb       | psel/penable  | paddr 3 bits, pwdata / prdata 32 bits
//
// One input item is taken per clock while the output queue has room; the result
// of an item passes the line store read, window shift, row sums and column sum.
// The line store read port and the window shift set the rate of one item per cycle.
// Results wait in a two-entry output queue; input stalls only when it is full.
// Reset clears counters, window and queue; the line store is not cleared.
// After the frame the source sends (KSIZE-1-KSIZE/2)*(width+1) drain items.
module binomial_gaussian_blur_core import bgb_pkg::*; #(
  parameter int KSIZE     = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  bgb_pixel_if.sink             pixels,
  bgb_result_if.source          results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int C       = KSIZE / 2;
  localparam int D       = KSIZE - 1 - KSIZE / 2;
  localparam int NLINE   = KSIZE - 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int LAG_MAX = D * MAX_WIDTH + D;
  localparam int LAG_W   = (LAG_MAX < 1) ? 1 : $clog2(LAG_MAX + 1);
  localparam int MW      = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 2;
  localparam int YW      = HEIGHT_REG_W + 2;
  localparam int RSW     = PIXEL_W + KSIZE - 1;
  localparam int TW      = PIXEL_W + 2 * (KSIZE - 1);

  // Configuration registers and their effective values.
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [LAG_W-1:0]        lag;
  logic                    cfg_wr;

  // Position counters.
  logic [CW-1:0]           in_column;
  logic [LAG_W-1:0]        item_count;
  logic [CW-1:0]           out_col;
  logic [HEIGHT_REG_W-1:0] out_row;

  // Accept stage.
  logic       accept;
  logic       advance;
  logic       primed;
  logic       rend0;
  logic       fend0;
  res_flags_t s0_flags;
  logic [KSIZE-1:0] col_mask0;
  logic [KSIZE-1:0] row_mask0;
  logic       bypass0;
  pixel_t     pixel0;
  logic       in_last;

  // Line store stage.
  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  pixel_t           s1_pixel;
  res_flags_t       s1_flags;
  logic [KSIZE-1:0] s1_col_mask;
  logic [KSIZE-1:0] s1_row_mask;
  logic             s1_bypass;
  logic [KSIZE-1:0][PIXEL_W-1:0] col;
  line_ctl_t        line_ctl;

  // Window stage.
  logic [KSIZE-1:0][KSIZE-1:0][PIXEL_W-1:0] win_q;
  logic             win_clear;
  logic             sw_valid;
  res_flags_t       sw_flags;
  logic [KSIZE-1:0] sw_col_mask;
  logic [KSIZE-1:0] sw_row_mask;
  logic [RSW-1:0]   hterm [KSIZE][KSIZE];
  logic [RSW-1:0]   rs_comb [KSIZE];

  // Column sum stage.
  logic             s3_valid;
  res_flags_t       s3_flags;
  logic [RSW-1:0]   s3_rs [KSIZE];
  logic [TW-1:0]    vterm [KSIZE];
  logic [TW-1:0]    total;

  // Output queue.
  result_t    fifo_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fifo_count;
  logic       push;
  logic       pop;

  // ---------------------------------------------------------------------------
  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(paddr[2]))
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Zero width or height count as one; width saturates at the line store depth.
  always_comb begin
    if (image_width == '0) begin
      eff_w = WIDTH_REG_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height == '0) ? HEIGHT_REG_W'(1) : image_height;
  end

  // Items that pass before the first result: D rows and D pixels.
  assign lag = LAG_W'(D * eff_w + D);

  // ---------------------------------------------------------------------------
  // Accept stage: flags, masks and counters are settled when the item enters.
  assign advance      = (fifo_count != 2'd2);
  assign pixels.ready = advance;
  assign accept       = pixels.valid && pixels.ready;

  assign primed  = (item_count >= lag);
  assign rend0   = (MW'(out_col) + MW'(1)) >= MW'(eff_w);
  assign fend0   = rend0 && ((YW'(out_row) + YW'(1)) >= YW'(eff_h));
  assign s0_flags = '{result: primed, row_end: primed && rend0, frame_end: primed && fend0};
  assign pixel0  = (pixels.cmd == CMD_DRAIN) ? '0 : pixels.pixel;
  assign in_last = (MW'(in_column) + MW'(1)) >= MW'(eff_w);

  // The item in the line store stage writes this entry at the same edge.
  assign bypass0 = s1_valid && (in_column == s1_col);

  // Window positions that fall inside the image.
  for (genvar k = 0; k < KSIZE; k++) begin : g_mask
    assign col_mask0[k] = (MW'(out_col) + MW'(k) >= MW'(C)) &&
                          (MW'(out_col) + MW'(k) < MW'(eff_w) + MW'(C));
    assign row_mask0[k] = (YW'(out_row) + YW'(k) >= YW'(C)) &&
                          (YW'(out_row) + YW'(k) < YW'(eff_h) + YW'(C));
  end

  // Position counters; the frame restarts after its last result or a register write.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_column  <= '0;
      item_count <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (accept) begin
      if (s0_flags.frame_end) begin
        in_column  <= '0;
        item_count <= '0;
        out_col    <= '0;
        out_row    <= '0;
      end else begin
        in_column <= in_last ? '0 : in_column + CW'(1);
        if (item_count < lag) begin
          item_count <= item_count + LAG_W'(1);
        end
        if (s0_flags.row_end) begin
          out_col <= '0;
          out_row <= out_row + HEIGHT_REG_W'(1);
        end else if (primed) begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store stage.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= in_column;
      s1_pixel    <= pixel0;
      s1_flags    <= s0_flags;
      s1_col_mask <= col_mask0;
      s1_row_mask <= row_mask0;
      s1_bypass   <= bypass0;
    end
  end

  assign line_ctl = '{rd_en: accept, wr_en: advance && s1_valid, bypass: s1_bypass};

  // Row chain: each row passes its stored pixel to the older row.
  assign col[KSIZE-1] = s1_pixel;

  for (genvar t = 0; t < NLINE; t++) begin : g_line
    bgb_line_cell #(
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .ctl     (line_ctl),
      .rd_addr (in_column),
      .wr_addr (s1_col),
      .wr_data (col[t+1]),
      .rd_q    (col[t])
    );
  end

  // ---------------------------------------------------------------------------
  // Window chain: the newest column enters the last cell.
  for (genvar k = 0; k < KSIZE; k++) begin : g_win
    win_ctl_t wctl;
    if (k == KSIZE - 1) begin : g_newest
      assign wctl = '{clear: rst || cfg_wr, shift: advance && s1_valid, flush: 1'b0};
      bgb_window_cell #(
        .KSIZE (KSIZE)
      ) u_win (
        .clk (clk),
        .ctl (wctl),
        .d   (col),
        .q   (win_q[k])
      );
    end else begin : g_older
      assign wctl = '{clear: rst || cfg_wr, shift: advance && s1_valid, flush: win_clear};
      bgb_window_cell #(
        .KSIZE (KSIZE)
      ) u_win (
        .clk (clk),
        .ctl (wctl),
        .d   (win_q[k+1]),
        .q   (win_q[k])
      );
    end
  end

  // After the last item of a frame the next shift starts from an empty window.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      win_clear <= 1'b0;
    end else if (advance && s1_valid) begin
      win_clear <= s1_flags.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      sw_valid <= 1'b0;
    end else if (advance) begin
      sw_valid <= s1_valid && s1_flags.result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      sw_flags    <= s1_flags;
      sw_col_mask <= s1_col_mask;
      sw_row_mask <= s1_row_mask;
    end
  end

  // Weighted row sums over the window, masked to the image.
  for (genvar t = 0; t < KSIZE; t++) begin : g_hrow
    for (genvar k = 0; k < KSIZE; k++) begin : g_hcol
      localparam int WS = binomial(KSIZE - 1, k);
      assign hterm[t][k] = (sw_row_mask[t] && sw_col_mask[k]) ?
                           RSW'(win_q[k][t]) * RSW'(WS) : '0;
    end
  end

  always_comb begin
    for (int t = 0; t < KSIZE; t++) begin
      rs_comb[t] = '0;
      for (int k = 0; k < KSIZE; k++) begin
        rs_comb[t] = rs_comb[t] + hterm[t][k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Column sum stage.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= sw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sw_valid) begin
      s3_flags <= sw_flags;
      s3_rs    <= rs_comb;
    end
  end

  for (genvar t = 0; t < KSIZE; t++) begin : g_vrow
    localparam int WT = binomial(KSIZE - 1, t);
    assign vterm[t] = TW'(s3_rs[t]) * TW'(WT);
  end

  always_comb begin
    total = '0;
    for (int t = 0; t < KSIZE; t++) begin
      total = total + vterm[t];
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue; the shift by the total weight is the top byte of the sum.
  assign push = advance && s3_valid;
  assign pop  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{blurred:   total[TW-1 -: PIXEL_W],
                            row_end:   s3_flags.row_end,
                            frame_end: s3_flags.frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fifo_count <= fifo_count + 2'd1;
        2'b01:   fifo_count <= fifo_count - 2'd1;
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  assign results.valid     = (fifo_count != '0);
  assign results.blurred   = fifo_mem[rd_ptr].blurred;
  assign results.row_end   = fifo_mem[rd_ptr].row_end;
  assign results.frame_end = fifo_mem[rd_ptr].frame_end;

  // ---------------------------------------------------------------------------
  // Checks.
  a_frame_end_ends_row: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.frame_end || results.row_end))
    else $error("frame end flagged on a result that does not end a row");

  a_restart_after_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && s0_flags.frame_end) |=>
      (in_column == '0 && item_count == '0 && out_col == '0 && out_row == '0))
    else $error("counters not cleared after the last result of a frame");

  a_position_in_image: assert property (@(posedge clk) disable iff (rst)
    (MW'(out_col) < MW'(eff_w)) && (out_row < eff_h) && (MW'(in_column) < MW'(eff_w)))
    else $error("position counter outside the image");

  a_center_inside: assert property (@(posedge clk) disable iff (rst)
    sw_valid |-> (sw_row_mask[C] && sw_col_mask[C]))
    else $error("window center masked out for a result");

endmodule

/* src/bgb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/bgb_line_cell.sv */
// One line store row: takes the newer row's pixel and hands its old pixel on.
module bgb_line_cell import bgb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  line_ctl_t                ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  pixel_t                   wr_data,
  output pixel_t                   rd_q
);

  pixel_t ram_q;
  pixel_t last_wr;

  bgb_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Keep the last written pixel for an item that read the same entry while it was written.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      last_wr <= wr_data;
    end
  end

  assign rd_q = ctl.bypass ? last_wr : ram_q;

endmodule

/* src/bgb_window_cell.sv */
// One column of the filter window; shifts toward the older neighbor on each item.
module bgb_window_cell import bgb_pkg::*; #(
  parameter int KSIZE = 5
) (
  input  logic                            clk,
  input  win_ctl_t                        ctl,
  input  logic [KSIZE-1:0][PIXEL_W-1:0]   d,
  output logic [KSIZE-1:0][PIXEL_W-1:0]   q
);

  // Flush loads zeros, as the window is emptied after the end of a frame.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= ctl.flush ? '0 : d;
    end
  end

endmodule

/* tb/sv/bgb_blur_checker.sv */
// Checker for the binomial blur: predicts each blurred item and compares the results.
`timescale 1ns / 100ps

module bgb_blur_checker import bgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  bgb_pixel_if                  pix,
  bgb_result_if                 res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    pending,
  output int                    fail_count
);

  localparam int KS       = 5;
  localparam int HALF     = KS / 2;
  localparam int LAG_ROWS = KS - 1 - HALF;
  localparam int MAX_W    = 1024;

  // Binomial row KSIZE-1; the 2-D weight is the product of a row and a column tap.
  localparam int unsigned TAP [KS] = '{1, 4, 6, 4, 1};

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  pixel_t      line_mem [KS-1][MAX_W];
  pixel_t      win [KS][KS];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_col;
  int unsigned out_row;
  result_t     blur_q [$];
  int          errs;

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // A register write or the end of a frame clears counters and window.
  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    for (int t = 0; t < KS; t++) begin
      for (int s = 0; s < KS; s++) begin
        win[t][s] = '0;
      end
    end
  endfunction

  // Only the first ten failures are printed; the rest are just counted.
  function automatic void log_error(string msg);
    errs++;
    if (errs <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Advance the line store and window by one pixel item and queue the blurred
  // value that this item completes, if any.
  function automatic void blur_pixel(logic cmd, pixel_t value);
    int unsigned       w;
    int unsigned       h;
    int unsigned       j;
    longint unsigned   pos;
    pixel_t            column [KS];
    int unsigned       sum;
    int                yy;
    int                xx;
    result_t           r;
    w   = active_width();
    h   = active_height();
    j   = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
    pos = longint'(in_row) * w + in_col;

    // Column at this input position, oldest row first; the line store shifts up.
    for (int t = 0; t < KS - 1; t++) begin
      column[t] = line_mem[t][j];
    end
    column[KS-1] = (cmd == CMD_DRAIN) ? '0 : value;
    for (int t = 0; t < KS - 1; t++) begin
      line_mem[t][j] = column[t+1];
    end
    for (int t = 0; t < KS; t++) begin
      for (int s = 0; s < KS - 1; s++) begin
        win[t][s] = win[t][s+1];
      end
      win[t][KS-1] = column[t];
    end

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end

    // The window trails the input by LAG_ROWS rows and LAG_ROWS columns.
    if (pos < longint'(LAG_ROWS) * w + LAG_ROWS) return;

    // Weighted sum with positions outside the image masked to zero.
    sum = 0;
    for (int t = 0; t < KS; t++) begin
      yy = int'(out_row) - HALF + t;
      if (yy < 0 || yy >= int'(h)) continue;
      for (int s = 0; s < KS; s++) begin
        xx = int'(out_col) - HALF + s;
        if (xx < 0 || xx >= int'(w)) continue;
        sum += TAP[t] * TAP[s] * win[t][s];
      end
    end
    r.blurred   = pixel_t'(sum >> (2 * (KS - 1)));
    r.row_end   = (out_col + 1 >= w);
    r.frame_end = r.row_end && (out_row + 1 >= h);
    blur_q.push_back(r);

    if (r.frame_end) begin
      restart_frame();
    end else if (r.row_end) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void check_result(pixel_t b, logic re, logic fe);
    result_t e;
    if (blur_q.size() == 0) begin
      log_error($sformatf("unexpected result: blurred %0d row_end %0b frame_end %0b",
                          b, re, fe));
      return;
    end
    e = blur_q.pop_front();
    if (b !== e.blurred || re !== e.row_end || fe !== e.frame_end) begin
      log_error($sformatf({"result mismatch: expected blurred %0d row_end %0b frame_end %0b,",
                           " got blurred %0d row_end %0b frame_end %0b"},
                          e.blurred, e.row_end, e.frame_end, b, re, fe));
    end
  endfunction

  // Register readback is compared with the shadow copy, zero extended.
  function automatic void check_readback(reg_index_t idx, logic [APB_DATA_W-1:0] got);
    logic [APB_DATA_W-1:0] want;
    case (idx)
      REG_IMAGE_WIDTH: want = APB_DATA_W'(width_reg);
      REG_IMAGE_HEIGHT: want = APB_DATA_W'(height_reg);
    endcase
    if (got !== want) begin
      log_error($sformatf("register %s readback: expected %0d got %0d", idx.name(), want, got));
    end
  endfunction

  // Watch configuration, pixel items and result items at every clock edge.
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      restart_frame();
      blur_q.delete();
      for (int t = 0; t < KS - 1; t++) begin
        for (int x = 0; x < MAX_W; x++) begin
          line_mem[t][x] = '0;
        end
      end
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_index_t'(paddr[2]))
            REG_IMAGE_WIDTH: width_reg = pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = pwdata[HEIGHT_REG_W-1:0];
          endcase
          restart_frame();
        end else begin
          check_readback(reg_index_t'(paddr[2]), prdata);
        end
      end
      if (pix.valid && pix.ready) begin
        blur_pixel(pix.cmd, pix.pixel);
      end
      if (res.valid && res.ready) begin
        check_result(res.blurred, res.row_end, res.frame_end);
      end
    end
    pending    <= blur_q.size();
    fail_count <= errs;
  end

endmodule

/* tb/sv/tb.sv */
// Top of the binomial blur testbench: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 100ps

module tb;
  import bgb_pkg::*;

  localparam logic CMD_PIXEL   = ~CMD_DRAIN;
  localparam logic APB_WRITE   = 1'b1;
  localparam logic APB_READ    = 1'b0;
  localparam int   DRAIN_LAG   = 2;        // rows and columns the output trails the input
  localparam int   MAX_W       = 1024;
  localparam int   RANDOM_ITEMS = 130;
  localparam int   WIDE_SLICE  = 16;
  localparam int   HOLD_CYCLES = 100;
  localparam int   CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          blur_pending;
  int          fail_count;
  int          cycle_cnt = 0;
  int          items_sent = 0;
  int          calm_left = 0;
  int unsigned cur_w;
  int unsigned cur_h;
  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        hold_req;

  bgb_pixel_if  pix_ch ();
  bgb_result_if res_ch ();

  binomial_gaussian_blur_core u_top (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch.sink),
    .results (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bgb_blur_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pending    (blur_pending),
    .fail_count (fail_count)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Grey values lean toward the extremes now and then.
  function automatic pixel_t pick_grey();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One register access: setup cycle, access cycle, then idle.
  task automatic apb_access(input logic wr, input reg_index_t idx,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both size registers, read them back and note the sizes in effect.
  task automatic set_frame(input logic [APB_DATA_W-1:0] w_word,
                           input logic [APB_DATA_W-1:0] h_word);
    int unsigned w;
    w = w_word[WIDTH_REG_W-1:0];
    apb_access(APB_WRITE, REG_IMAGE_WIDTH, w_word);
    apb_access(APB_WRITE, REG_IMAGE_HEIGHT, h_word);
    apb_access(APB_READ, REG_IMAGE_WIDTH, '0);
    apb_access(APB_READ, REG_IMAGE_HEIGHT, '0);
    cur_w = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
    cur_h = (h_word[HEIGHT_REG_W-1:0] == '0) ? 1 : h_word[HEIGHT_REG_W-1:0];
  endtask

  // Offer one pixel item, with an occasional idle burst first, and wait for acceptance.
  task automatic push_pixel(input logic cmd, input pixel_t value);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
    end else if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 60);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.cmd   <= cmd;
    pix_ch.pixel <= value;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // A whole frame plus its drain items; some early drains and some late pixels.
  task automatic stream_frame();
    int unsigned n_img;
    int unsigned n_all;
    n_img = cur_w * cur_h;
    n_all = n_img + DRAIN_LAG * cur_w + DRAIN_LAG;
    for (int unsigned i = 0; i < n_all; i++) begin
      if (i < n_img) begin
        push_pixel(($urandom_range(0, 15) == 0) ? CMD_DRAIN : CMD_PIXEL, pick_grey());
      end else begin
        push_pixel(($urandom_range(0, 5) == 0) ? CMD_PIXEL : CMD_DRAIN, pick_grey());
      end
    end
  endtask

  // Stop offering and wait until every expected result is out and the pipe is empty.
  task automatic wait_results_out();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (blur_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side: random ready bursts, and one long hold-off on request.
  initial begin : result_sink
    int span;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        hold_req     <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        span = $urandom_range(1, 16);
        repeat (span) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        span = $urandom_range(1, 24);
        repeat (span) @(posedge clk);
      end
    end
  end

  // Pixel and register stimulus, then the verdict.
  initial begin : stimulus
    int                    base;
    int                    n_frames;
    logic [APB_DATA_W-1:0] w_word;
    logic [APB_DATA_W-1:0] h_word;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_ch.valid = 1'b0;
    pix_ch.cmd   = CMD_PIXEL;
    pix_ch.pixel = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers hold their reset sizes.
    apb_access(APB_READ, REG_IMAGE_WIDTH, '0);
    apb_access(APB_READ, REG_IMAGE_HEIGHT, '0);

    // 3x2 frame: extreme greys, an early drain inside the frame, a pixel in the drain.
    set_frame(3, 2);
    push_pixel(CMD_PIXEL, 8'd255);
    push_pixel(CMD_PIXEL, 8'd0);
    push_pixel(CMD_PIXEL, 8'd255);
    push_pixel(CMD_DRAIN, 8'hAA);
    push_pixel(CMD_PIXEL, 8'd255);
    push_pixel(CMD_PIXEL, 8'd128);
    repeat (3) push_pixel(CMD_DRAIN, 8'h00);
    push_pixel(CMD_PIXEL, 8'd255);
    repeat (4) push_pixel(CMD_DRAIN, 8'hFF);
    wait_results_out();

    // Zero width and zero height both count as one.
    set_frame(0, 0);
    push_pixel(CMD_PIXEL, 8'd255);
    repeat (4) push_pixel(CMD_DRAIN, pick_grey());
    wait_results_out();

    // Widest rows: an out-of-range width saturates, then the exact maximum.
    // Only the head of each frame is sent; the next register write restarts it.
    set_frame(32'h7FF, 2);
    repeat (WIDE_SLICE) push_pixel(CMD_PIXEL, pick_grey());
    wait_results_out();
    set_frame(MAX_W, 1);
    repeat (WIDE_SLICE) push_pixel(CMD_PIXEL, pick_grey());
    wait_results_out();

    // Random small frames, mostly well formed, some cut short or scrambled.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w_word = 0;
        1: w_word = 1;
        default: w_word = $urandom_range(2, 9);
      endcase
      h_word = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        w_word = w_word | ($urandom() & ~32'h7FF);
        h_word = h_word | ($urandom() & ~32'hFFFF);
      end
      set_frame(w_word, h_word);
      n_frames = $urandom_range(1, 3);
      repeat (n_frames) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 2 * cur_w * cur_h + 4)) begin
            push_pixel(1'($urandom_range(0, 1)), pick_grey());
          end
        end else begin
          stream_frame();
        end
      end
      wait_results_out();
    end

    // Long hold-off on results while pixels keep coming, so the input stalls.
    set_frame(4, 8);
    tx_idle_on = 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    while (hold_req) @(posedge clk);
    stream_frame();
    tx_idle_on = 1'b1;
    wait_results_out();

    // Tall frame, one column wide, with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    set_frame(1, 40);
    stream_frame();
    wait_results_out();

    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
